@@ hdl/wsa_pkg.sv @@
// Shared types and constants for the weighted similarity window accumulator.
`timescale 1ns / 1ps

package wsa_pkg;

  localparam int COORD_BITS     = 12;
  localparam int LOG_ITERATIONS = 16;

  localparam int VAL_W   = 16;
  localparam int DIM_W   = 11;
  localparam int SUM_W   = 48;
  localparam int CFG_IDX_W = 3;

  localparam int Q_FRAC    = 12;
  localparam int FRAC_BITS = 28;

  localparam logic [30:0] LN2_Q31         = 31'd1488522236;
  localparam logic [24:0] HALF_LN_2PI_Q24 = 25'd15417230;

  localparam logic             RST_SIM_MODE   = 1'b1;
  localparam logic             RST_NORMALIZE  = 1'b0;
  localparam logic             RST_SKIP       = 1'b0;
  localparam logic [VAL_W-1:0] RST_FUDGE      = 16'd4;
  localparam logic [VAL_W-1:0] RST_FILL       = 16'd0;
  localparam logic [DIM_W-1:0] RST_DIM        = 11'd2047;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIM_MODE     = 3'd0,
    CFG_NORMALIZE    = 3'd1,
    CFG_SKIP_MISSING = 3'd2,
    CFG_FUDGE        = 3'd3,
    CFG_FILL_VALUE   = 3'd4,
    CFG_IMAGE_HEIGHT = 3'd5,
    CFG_IMAGE_WIDTH  = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_W,
    S_MUL_D,
    S_LOG_NORM,
    S_LOG_ITER,
    S_LOG_MAG,
    S_LOG_SCALE,
    S_TERM,
    S_ACC
  } state_e;

endpackage

@@ hdl/wsa_if.sv @@
// Valid/ready channel interfaces for tap requests and similarity results.
`timescale 1ns / 1ps

interface wsa_tap_if #(
  parameter int CoordBits = wsa_pkg::COORD_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [CoordBits-1:0]   in_row;
  logic signed [CoordBits-1:0]   in_col;
  logic signed [wsa_pkg::VAL_W-1:0] pixel;
  logic                          pixel_missing;
  logic signed [wsa_pkg::VAL_W-1:0] template_value;
  logic [wsa_pkg::VAL_W-1:0]     weight_value;
  logic                          last_tap;

  modport source (
    output valid, in_row, in_col, pixel, pixel_missing, template_value, weight_value,
           last_tap,
    input  ready
  );
  modport sink (
    input  valid, in_row, in_col, pixel, pixel_missing, template_value, weight_value,
           last_tap,
    output ready
  );
endinterface

interface wsa_sum_if;
  logic                             valid;
  logic                             ready;
  logic signed [wsa_pkg::SUM_W-1:0] sum;
  logic                             sum_invalid;

  modport source (output valid, sum, sum_invalid, input ready);
  modport sink (input valid, sum, sum_invalid, output ready);
endinterface

@@ hdl/weighted_similarity_window_accumulator_unit.sv @@
// Top level: weighted similarity accumulator over window taps, one shared multiplier.
`timescale 1ns / 1ps

// One tap request is taken whenever the sequencer is idle; a tap then occupies it through
// the weight product (S_MUL_W), the square with squared distance (S_MUL_D), the logarithm
// steps with normalization on (S_LOG_NORM, repeated S_LOG_ITER, S_LOG_MAG, S_LOG_SCALE),
// then S_TERM and S_ACC. A missing pixel inside the image goes straight to S_ACC. The steps
// follow from the single 32x32 multiplier, which serves the weight product, the square, every
// squaring step of the logarithm and its final scaling, one use per cycle. On a last tap the
// result goes to an output register; the next tap is accepted while that result waits, and
// only a following last tap holds in its final state until the register is free.
module weighted_similarity_window_accumulator_unit #(
  parameter int CoordBits     = wsa_pkg::COORD_BITS,
  parameter int LogIterations = wsa_pkg::LOG_ITERATIONS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  wsa_tap_if.sink                         tap_i,
  wsa_sum_if.source                       sum_o,
  input  logic                            cfg_we_i,
  input  logic [wsa_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [wsa_pkg::VAL_W-1:0]       cfg_data_i
);

  localparam int CntW = $clog2(LogIterations + 1);
  localparam int CmpW = (CoordBits > wsa_pkg::DIM_W) ? CoordBits : wsa_pkg::DIM_W;

  wsa_pkg::state_e state_q, state_d;

  logic                            sim_mode_q, normalize_q, skip_q;
  logic [wsa_pkg::VAL_W-1:0]       fudge_q;
  logic signed [wsa_pkg::VAL_W-1:0] fill_q;
  logic [wsa_pkg::DIM_W-1:0]       height_q, width_q;

  logic [15:0]                     ad_q, ad_d;
  logic [15:0]                     w_q, w_d;
  logic                            last_q, last_d;
  logic [35:0]                     m_q, m_d;
  logic [4:0]                      e_q, e_d;
  logic [30:0]                     x_q, x_d;
  logic [27:0]                     frac_q, frac_d;
  logic [CntW-1:0]                 cnt_q, cnt_d;
  logic                            neg_q, neg_d;
  logic [31:0]                     mag_q, mag_d;
  logic [26:0]                     r_q, r_d;
  logic signed [37:0]              term_q, term_d;
  logic signed [wsa_pkg::SUM_W-1:0] acc_q, acc_d;
  logic                            inv_q, inv_d;
  logic                            out_valid_q, out_valid_d;
  logic signed [wsa_pkg::SUM_W-1:0] out_sum_q, out_sum_d;
  logic                            out_inv_q, out_inv_d;

  logic [31:0]                     mul_a, mul_b;
  logic [63:0]                     mul_p;

  logic signed [CoordBits-1:0]     row, col;
  logic                            in_image;
  logic signed [16:0]              diff;
  logic [16:0]                     diff_abs;

  assign row = tap_i.in_row;
  assign col = tap_i.in_col;

  assign in_image = !row[CoordBits-1] && !col[CoordBits-1] &&
                    (CmpW'(unsigned'(row)) < CmpW'(height_q)) &&
                    (CmpW'(unsigned'(col)) < CmpW'(width_q));

  always_comb begin
    if (in_image) begin
      diff = 17'(tap_i.pixel) - 17'(tap_i.template_value);
    end else begin
      diff = 17'(fill_q) - 17'(tap_i.template_value);
    end
    diff_abs = diff[16] ? 17'(-diff) : 17'(diff);
  end

  always_comb begin
    unique case (state_q)
      wsa_pkg::S_MUL_W: begin
        mul_a = 32'(w_q);
        mul_b = 32'(ad_q);
      end
      wsa_pkg::S_MUL_D: begin
        mul_a = m_q[31:0];
        mul_b = 32'(ad_q);
      end
      wsa_pkg::S_LOG_ITER: begin
        mul_a = 32'(x_q);
        mul_b = 32'(x_q);
      end
      wsa_pkg::S_LOG_SCALE: begin
        mul_a = mag_q;
        mul_b = 32'(wsa_pkg::LN2_Q31);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    logic [16:0]        log_arg;
    logic [4:0]         top;
    logic [31:0]        sq;
    logic [5:0]         frac_sh;
    logic [47:0]        rnd_sq;
    logic [63:0]        rnd_ln;
    logic [36:0]        m_inc;
    logic signed [37:0] h_s;
    logic signed [49:0] sum_w;
    logic signed [wsa_pkg::SUM_W-1:0] sat;

    state_d     = state_q;
    ad_d        = ad_q;
    w_d         = w_q;
    last_d      = last_q;
    m_d         = m_q;
    e_d         = e_q;
    x_d         = x_q;
    frac_d      = frac_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    r_d         = r_q;
    term_d      = term_q;
    acc_d       = acc_q;
    inv_d       = inv_q;
    out_valid_d = out_valid_q && !sum_o.ready;
    out_sum_d   = out_sum_q;
    out_inv_d   = out_inv_q;
    tap_i.ready = 1'b0;

    log_arg = 17'(w_q) + 17'(fudge_q);
    if (log_arg == '0) begin
      log_arg = 17'd1;
    end
    top = '0;
    for (int i = 0; i < 17; i++) begin
      if (log_arg[i]) begin
        top = 5'(i);
      end
    end

    sq      = mul_p[61:30];
    frac_sh = 6'(wsa_pkg::FRAC_BITS) - 6'(cnt_q);
    rnd_sq  = mul_p[47:0] + 48'd2048;
    rnd_ln  = mul_p + (64'd1 << 35);
    m_inc   = 37'(m_q) + 37'd1;
    h_s     = neg_q ? -signed'(38'(r_q)) : signed'(38'(r_q));
    sum_w   = 50'(acc_q) + 50'(term_q);
    if (sum_w[49:47] == 3'b000 || sum_w[49:47] == 3'b111) begin
      sat = sum_w[wsa_pkg::SUM_W-1:0];
    end else if (sum_w[49]) begin
      sat = {1'b1, {(wsa_pkg::SUM_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(wsa_pkg::SUM_W-1){1'b1}}};
    end

    unique case (state_q)
      wsa_pkg::S_IDLE: begin
        tap_i.ready = 1'b1;
        if (tap_i.valid) begin
          ad_d   = diff_abs[15:0];
          w_d    = tap_i.weight_value;
          last_d = tap_i.last_tap;
          if (in_image && tap_i.pixel_missing) begin
            inv_d   = inv_q || !skip_q;
            term_d  = '0;
            state_d = wsa_pkg::S_ACC;
          end else begin
            state_d = wsa_pkg::S_MUL_W;
          end
        end
      end
      wsa_pkg::S_MUL_W: begin
        m_d = 36'(mul_p[31:0]);
        if (sim_mode_q) begin
          state_d = wsa_pkg::S_MUL_D;
        end else if (normalize_q) begin
          state_d = wsa_pkg::S_LOG_NORM;
        end else begin
          state_d = wsa_pkg::S_TERM;
        end
      end
      wsa_pkg::S_MUL_D: begin
        m_d     = rnd_sq[47:12];
        state_d = normalize_q ? wsa_pkg::S_LOG_NORM : wsa_pkg::S_TERM;
      end
      wsa_pkg::S_LOG_NORM: begin
        e_d     = top;
        x_d     = 31'({log_arg, 14'b0} << (5'd16 - top));
        frac_d  = '0;
        cnt_d   = CntW'(1);
        state_d = wsa_pkg::S_LOG_ITER;
      end
      wsa_pkg::S_LOG_ITER: begin
        if (sq[31]) begin
          x_d = sq[31:1];
          if (6'(cnt_q) <= 6'(wsa_pkg::FRAC_BITS)) begin
            frac_d = frac_q | (28'd1 << frac_sh[4:0]);
          end
        end else begin
          x_d = sq[30:0];
        end
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(LogIterations)) begin
          state_d = wsa_pkg::S_LOG_MAG;
        end
      end
      wsa_pkg::S_LOG_MAG: begin
        if (e_q >= 5'(wsa_pkg::Q_FRAC)) begin
          neg_d = 1'b0;
          mag_d = {4'(e_q - 5'(wsa_pkg::Q_FRAC)), frac_q};
        end else begin
          neg_d = 1'b1;
          mag_d = {4'(5'(wsa_pkg::Q_FRAC) - e_q), 28'b0} - 32'(frac_q);
        end
        state_d = wsa_pkg::S_LOG_SCALE;
      end
      wsa_pkg::S_LOG_SCALE: begin
        r_d     = rnd_ln[62:36];
        state_d = wsa_pkg::S_TERM;
      end
      wsa_pkg::S_TERM: begin
        if (normalize_q) begin
          term_d = h_s - signed'(38'(wsa_pkg::HALF_LN_2PI_Q24)) -
                   signed'(38'(m_inc[36:1]));
        end else begin
          term_d = -signed'(38'(m_q));
        end
        state_d = wsa_pkg::S_ACC;
      end
      wsa_pkg::S_ACC: begin
        if (!last_q) begin
          acc_d   = sat;
          state_d = wsa_pkg::S_IDLE;
        end else if (!out_valid_q || sum_o.ready) begin
          out_valid_d = 1'b1;
          out_sum_d   = inv_q ? '0 : sat;
          out_inv_d   = inv_q;
          acc_d       = '0;
          inv_d       = 1'b0;
          state_d     = wsa_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = wsa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wsa_pkg::S_IDLE;
      acc_q       <= '0;
      inv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      inv_q       <= inv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sim_mode_q  <= wsa_pkg::RST_SIM_MODE;
      normalize_q <= wsa_pkg::RST_NORMALIZE;
      skip_q      <= wsa_pkg::RST_SKIP;
      fudge_q     <= wsa_pkg::RST_FUDGE;
      fill_q      <= wsa_pkg::RST_FILL;
      height_q    <= wsa_pkg::RST_DIM;
      width_q     <= wsa_pkg::RST_DIM;
    end else if (cfg_we_i) begin
      unique case (wsa_pkg::cfg_idx_e'(cfg_idx_i))
        wsa_pkg::CFG_SIM_MODE:     sim_mode_q  <= cfg_data_i[0];
        wsa_pkg::CFG_NORMALIZE:    normalize_q <= cfg_data_i[0];
        wsa_pkg::CFG_SKIP_MISSING: skip_q      <= cfg_data_i[0];
        wsa_pkg::CFG_FUDGE:        fudge_q     <= cfg_data_i;
        wsa_pkg::CFG_FILL_VALUE:   fill_q      <= signed'(cfg_data_i);
        wsa_pkg::CFG_IMAGE_HEIGHT: height_q    <= cfg_data_i[wsa_pkg::DIM_W-1:0];
        wsa_pkg::CFG_IMAGE_WIDTH:  width_q     <= cfg_data_i[wsa_pkg::DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    ad_q      <= ad_d;
    w_q       <= w_d;
    last_q    <= last_d;
    m_q       <= m_d;
    e_q       <= e_d;
    x_q       <= x_d;
    frac_q    <= frac_d;
    cnt_q     <= cnt_d;
    neg_q     <= neg_d;
    mag_q     <= mag_d;
    r_q       <= r_d;
    term_q    <= term_d;
    out_sum_q <= out_sum_d;
    out_inv_q <= out_inv_d;
  end

  assign sum_o.valid       = out_valid_q;
  assign sum_o.sum         = out_sum_q;
  assign sum_o.sum_invalid = out_inv_q;

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wsa_pkg::S_ACC && last_q && state_d == wsa_pkg::S_IDLE)
      |=> (acc_q == '0 && !inv_q && out_valid_q))
    else $error("accumulator not cleared after result");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_inv_q) |-> (out_sum_q == '0))
    else $error("invalid result carries nonzero sum");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wsa_pkg::S_LOG_ITER)
      |-> (cnt_q >= CntW'(1) && cnt_q <= CntW'(LogIterations)))
    else $error("log iteration count out of range");

  a_mant_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wsa_pkg::S_LOG_ITER) |-> x_q[30])
    else $error("log mantissa lost normalization");

  a_hold_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wsa_pkg::S_ACC && last_q && out_valid_q && !sum_o.ready)
      |=> (state_q == wsa_pkg::S_ACC && out_valid_q))
    else $error("result overwrote a pending result");

endmodule

@@ dv/weighted_similarity_window_accumulator_unit_tb.sv @@
// Testbench for the weighted similarity accumulator: directed and random taps against a predictor.
`timescale 1ns / 1ps

module weighted_similarity_window_accumulator_unit_tb;

  localparam int CLK_HALF      = 2;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int PHASE_TAPS    = 100;
  localparam int RANDOM_PHASES = 8;
  localparam logic [wsa_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam longint SUM_MAX = (longint'(1) <<< (wsa_pkg::SUM_W - 1)) - 1;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  typedef struct {
    logic signed [wsa_pkg::COORD_BITS-1:0] row;
    logic signed [wsa_pkg::COORD_BITS-1:0] col;
    logic signed [wsa_pkg::VAL_W-1:0]      pix;
    logic                                  miss;
    logic signed [wsa_pkg::VAL_W-1:0]      tmpl;
    logic [wsa_pkg::VAL_W-1:0]             wgt;
    logic                                  last;
  } tap_t;

  typedef struct {
    logic [wsa_pkg::SUM_W-1:0] sum;
    logic                      invalid;
  } sum_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                          cfg_we_i;
  logic [wsa_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [wsa_pkg::VAL_W-1:0]     cfg_data_i;

  wsa_tap_if tap_if ();
  wsa_sum_if sum_if ();

  weighted_similarity_window_accumulator_unit uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tap_i     (tap_if),
    .sum_o     (sum_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // register copies and accumulator state
  logic                             cfg_sim_mode;
  logic                             cfg_normalize;
  logic                             cfg_skip;
  logic [wsa_pkg::VAL_W-1:0]        cfg_fudge;
  logic signed [wsa_pkg::VAL_W-1:0] cfg_fill;
  logic [wsa_pkg::DIM_W-1:0]        cfg_height;
  logic [wsa_pkg::DIM_W-1:0]        cfg_width;
  longint                           acc_q24;
  logic                             invalid_pending;

  tap_t tap_queue[$];
  sum_t expected_sums[$];
  tap_t cur_tap;

  int tap_gap_max, sum_stall_max, miss_pct;
  int gap_left, stall_left, stall_draw, quiet_cycles;
  int taps_queued, taps_accepted, windows_closed, results_checked, invalid_results;
  int taps_outside, taps_missing, settings_used, error_count;

  task automatic report_error(input string msg);
    error_count++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic longint half_ln_weight(input logic [wsa_pkg::VAL_W:0] arg);
    logic [wsa_pkg::VAL_W:0] a;
    int top, i;
    logic [63:0] x, frac, mag, r;
    longint l2;
    a = (arg == '0) ? 17'd1 : arg;
    top = wsa_pkg::VAL_W;
    while (top > 0 && !a[top]) top--;
    x = 64'(a) << (30 - top);
    frac = '0;
    for (i = 1; i <= wsa_pkg::LOG_ITERATIONS; i++) begin
      x = (x * x) >> 30;
      if (x >= (64'd1 << 31)) begin
        x = x >> 1;
        if (i <= wsa_pkg::FRAC_BITS) frac = frac | (64'd1 << (wsa_pkg::FRAC_BITS - i));
      end
    end
    l2 = longint'(top - wsa_pkg::Q_FRAC) * (longint'(1) <<< wsa_pkg::FRAC_BITS) +
         longint'(frac);
    mag = (l2 < 0) ? 64'(-l2) : 64'(l2);
    r = (mag * 64'(wsa_pkg::LN2_Q31) + (64'd1 << 35)) >> 36;
    return (l2 < 0) ? -longint'(r) : longint'(r);
  endfunction

  task automatic accumulate_tap(input tap_t t);
    int r, c, pix;
    logic in_image, miss;
    longint d, mag, term, s;
    sum_t res;
    r = t.row;
    c = t.col;
    in_image = r >= 0 && r < int'(cfg_height) && c >= 0 && c < int'(cfg_width);
    pix = in_image ? int'(t.pix) : int'(cfg_fill);
    miss = in_image && t.miss;
    if (!in_image) taps_outside++;
    if (miss) begin
      taps_missing++;
      if (!cfg_skip) invalid_pending = 1'b1;
    end else begin
      d = longint'(pix) - longint'(t.tmpl);
      if (d < 0) d = -d;
      if (cfg_sim_mode)
        mag = (longint'(t.wgt) * d * d + (longint'(1) <<< (wsa_pkg::Q_FRAC - 1)))
              >>> wsa_pkg::Q_FRAC;
      else
        mag = longint'(t.wgt) * d;
      if (cfg_normalize)
        term = -((mag + 1) >>> 1) + half_ln_weight({1'b0, t.wgt} + {1'b0, cfg_fudge})
               - longint'(wsa_pkg::HALF_LN_2PI_Q24);
      else
        term = -mag;
      s = acc_q24 + term;
      if (s > SUM_MAX) s = SUM_MAX;
      else if (s < SUM_MIN) s = SUM_MIN;
      acc_q24 = s;
    end
    if (t.last) begin
      res.invalid = invalid_pending;
      res.sum = invalid_pending ? '0 : acc_q24[wsa_pkg::SUM_W-1:0];
      expected_sums.push_back(res);
      windows_closed++;
      acc_q24 = 0;
      invalid_pending = 1'b0;
    end
  endtask

  task automatic add_tap(input tap_t t);
    tap_queue.push_back(t);
    taps_queued++;
  endtask

  task automatic add_directed(input int row, input int col,
                              input logic [wsa_pkg::VAL_W-1:0] pix, input logic miss,
                              input logic [wsa_pkg::VAL_W-1:0] tmpl,
                              input logic [wsa_pkg::VAL_W-1:0] wgt, input logic last);
    tap_t t;
    t.row = wsa_pkg::COORD_BITS'(row);
    t.col = wsa_pkg::COORD_BITS'(col);
    t.pix = pix;
    t.miss = miss;
    t.tmpl = tmpl;
    t.wgt = wgt;
    t.last = last;
    add_tap(t);
  endtask

  function automatic logic signed [wsa_pkg::COORD_BITS-1:0] pick_coord(input int dim);
    int v;
    case ($urandom_range(0, 9))
      0: v = -int'($urandom_range(1, 3));
      1: v = dim + int'($urandom_range(0, 2));
      2: v = int'($urandom());
      default: v = (dim > 0) ? int'($urandom_range(0, dim - 1)) : int'($urandom_range(0, 2047));
    endcase
    return wsa_pkg::COORD_BITS'(v);
  endfunction

  function automatic logic signed [wsa_pkg::VAL_W-1:0] pick_value();
    logic signed [wsa_pkg::VAL_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = 16'sh7FFF;
      1: v = 16'sh8000;
      2: v = wsa_pkg::VAL_W'($urandom_range(0, 63)) - 16'sd32;
      default: v = wsa_pkg::VAL_W'($urandom());
    endcase
    return v;
  endfunction

  task automatic add_random_tap(input logic last);
    tap_t t;
    t.row = pick_coord(int'(cfg_height));
    t.col = pick_coord(int'(cfg_width));
    t.pix = pick_value();
    t.miss = $urandom_range(0, 99) < miss_pct;
    if ($urandom_range(0, 2) == 0)
      t.tmpl = t.pix + wsa_pkg::VAL_W'($urandom_range(0, 15)) - 16'sd8;
    else t.tmpl = pick_value();
    case ($urandom_range(0, 7))
      0: t.wgt = '0;
      1: t.wgt = '1;
      2: t.wgt = wsa_pkg::VAL_W'($urandom_range(1, 64));
      default: t.wgt = wsa_pkg::VAL_W'($urandom());
    endcase
    t.last = last;
    add_tap(t);
  endtask

  task automatic write_reg(input logic [wsa_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wsa_pkg::VAL_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      wsa_pkg::CFG_SIM_MODE:     cfg_sim_mode  = data[0];
      wsa_pkg::CFG_NORMALIZE:    cfg_normalize = data[0];
      wsa_pkg::CFG_SKIP_MISSING: cfg_skip      = data[0];
      wsa_pkg::CFG_FUDGE:        cfg_fudge     = data;
      wsa_pkg::CFG_FILL_VALUE:   cfg_fill      = data;
      wsa_pkg::CFG_IMAGE_HEIGHT: cfg_height    = data[wsa_pkg::DIM_W-1:0];
      wsa_pkg::CFG_IMAGE_WIDTH:  cfg_width     = data[wsa_pkg::DIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // hold until every request is taken and every result is back, then let the core settle
  task automatic wait_idle();
    do @(negedge clk_i);
    while (taps_accepted != taps_queued || expected_sums.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [wsa_pkg::VAL_W-1:0] pick_extreme(
      input logic [wsa_pkg::VAL_W-1:0] lo, input logic [wsa_pkg::VAL_W-1:0] hi);
    logic [wsa_pkg::VAL_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = lo;
      1: v = hi;
      default: v = wsa_pkg::VAL_W'($urandom());
    endcase
    return v;
  endfunction

  function automatic logic [wsa_pkg::VAL_W-1:0] pick_dim();
    logic [wsa_pkg::VAL_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = 16'd1;
      1: v = 16'd2047;
      2: v = wsa_pkg::VAL_W'($urandom_range(1, 16));
      3: v = 16'd0;
      default: v = wsa_pkg::VAL_W'($urandom_range(1, 2047));
    endcase
    return v;
  endfunction

  task automatic randomize_settings(input int phase);
    write_reg(wsa_pkg::CFG_SIM_MODE, wsa_pkg::VAL_W'($urandom_range(0, 1)));
    write_reg(wsa_pkg::CFG_NORMALIZE, wsa_pkg::VAL_W'($urandom_range(0, 1)));
    write_reg(wsa_pkg::CFG_SKIP_MISSING, wsa_pkg::VAL_W'($urandom_range(0, 1)));
    write_reg(wsa_pkg::CFG_FUDGE, pick_extreme(16'h0000, 16'hFFFF));
    write_reg(wsa_pkg::CFG_FILL_VALUE, pick_extreme(16'h8000, 16'h7FFF));
    write_reg(wsa_pkg::CFG_IMAGE_HEIGHT, pick_dim());
    write_reg(wsa_pkg::CFG_IMAGE_WIDTH, pick_dim());
    end_writes();
    case (phase)
      0: begin
        tap_gap_max = 0;
        sum_stall_max = 0;
      end
      1: begin
        tap_gap_max = 15;
        sum_stall_max = 15;
      end
      default: begin
        tap_gap_max = $urandom_range(0, 1) ? 15 : 0;
        sum_stall_max = $urandom_range(0, 1) ? 15 : 0;
      end
    endcase
    case ($urandom_range(0, 2))
      0: miss_pct = 0;
      1: miss_pct = 10;
      default: miss_pct = 40;
    endcase
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_if.valid          <= 1'b0;
      tap_if.in_row         <= '0;
      tap_if.in_col         <= '0;
      tap_if.pixel          <= '0;
      tap_if.pixel_missing  <= 1'b0;
      tap_if.template_value <= '0;
      tap_if.weight_value   <= '0;
      tap_if.last_tap       <= 1'b0;
      gap_left <= 0;
    end else begin
      if (tap_if.valid && tap_if.ready) begin
        accumulate_tap(cur_tap);
        taps_accepted++;
      end
      if (!tap_if.valid || tap_if.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          tap_if.valid <= 1'b0;
        end else if (tap_queue.size() > 0) begin
          cur_tap = tap_queue.pop_front();
          tap_if.in_row         <= cur_tap.row;
          tap_if.in_col         <= cur_tap.col;
          tap_if.pixel          <= cur_tap.pix;
          tap_if.pixel_missing  <= cur_tap.miss;
          tap_if.template_value <= cur_tap.tmpl;
          tap_if.weight_value   <= cur_tap.wgt;
          tap_if.last_tap       <= cur_tap.last;
          tap_if.valid          <= 1'b1;
          gap_left <= $urandom_range(0, tap_gap_max);
        end else begin
          tap_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_if.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (sum_if.valid && sum_if.ready) begin
        if (expected_sums.size() == 0) begin
          report_error($sformatf("unexpected result sum=%0h invalid=%0b",
                                 sum_if.sum, sum_if.sum_invalid));
        end else begin
          if (sum_if.sum !== expected_sums[0].sum)
            report_error($sformatf("sum got %0h expected %0h",
                                   sum_if.sum, expected_sums[0].sum));
          if (sum_if.sum_invalid !== expected_sums[0].invalid)
            report_error($sformatf("sum_invalid got %0b expected %0b",
                                   sum_if.sum_invalid, expected_sums[0].invalid));
          if (expected_sums[0].invalid) invalid_results++;
          void'(expected_sums.pop_front());
          results_checked++;
        end
        stall_draw = $urandom_range(0, sum_stall_max);
        stall_left <= stall_draw;
        sum_if.ready <= (stall_draw == 0);
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        sum_if.ready <= (stall_left == 1);
      end else begin
        sum_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (tap_if.valid && tap_if.ready) || (sum_if.valid && sum_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no request moved for %0d cycles", quiet_cycles);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int p, n, len, k;
    bit broken;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    cfg_sim_mode = wsa_pkg::RST_SIM_MODE;
    cfg_normalize = wsa_pkg::RST_NORMALIZE;
    cfg_skip = wsa_pkg::RST_SKIP;
    cfg_fudge = wsa_pkg::RST_FUDGE;
    cfg_fill = wsa_pkg::RST_FILL;
    cfg_height = wsa_pkg::RST_DIM;
    cfg_width = wsa_pkg::RST_DIM;
    acc_q24 = 0;
    invalid_pending = 1'b0;
    tap_gap_max = 0;
    sum_stall_max = 0;
    miss_pct = 0;
    settings_used = 1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: squared distance, borders, missing without skip
    add_directed(0, 0, 16'h7FFF, 1'b0, 16'h8000, 16'hFFFF, 1'b1);
    add_directed(2046, 2046, 16'h8000, 1'b0, 16'h7FFF, 16'hFFFF, 1'b0);
    add_directed(2047, 0, 16'h1234, 1'b0, 16'h8000, 16'hFFFF, 1'b0);
    add_directed(-2048, -2048, 16'h0100, 1'b1, 16'h0200, 16'h1000, 1'b0);
    add_directed(5, 5, 16'h0000, 1'b1, 16'h0000, 16'h0064, 1'b1);
    add_directed(0, -1, 16'h0064, 1'b1, 16'h0000, 16'h1000, 1'b1);
    wait_idle();

    // absolute distance, skip missing, one-pixel image, unmapped index
    write_reg(wsa_pkg::CFG_SIM_MODE, 16'h0000);
    write_reg(wsa_pkg::CFG_SKIP_MISSING, 16'h0001);
    write_reg(wsa_pkg::CFG_FILL_VALUE, 16'h8000);
    write_reg(wsa_pkg::CFG_IMAGE_HEIGHT, 16'h0001);
    write_reg(wsa_pkg::CFG_IMAGE_WIDTH, 16'h0001);
    write_reg(CFG_UNUSED, 16'hFFFF);
    end_writes();
    tap_gap_max = 15;
    sum_stall_max = 15;
    add_directed(0, 0, 16'h7FFF, 1'b1, 16'h0000, 16'hFFFF, 1'b0);
    add_directed(0, 1, 16'h0000, 1'b0, 16'h7FFF, 16'hFFFF, 1'b0);
    add_directed(1, 0, 16'h0000, 1'b0, 16'h0000, 16'h0001, 1'b0);
    add_directed(0, 0, 16'h8000, 1'b0, 16'h7FFF, 16'hFFFF, 1'b1);
    add_directed(0, 0, 16'h0000, 1'b1, 16'h0000, 16'h0000, 1'b1);
    wait_idle();

    // normalization with zero log argument, empty image
    write_reg(wsa_pkg::CFG_SIM_MODE, 16'h0001);
    write_reg(wsa_pkg::CFG_NORMALIZE, 16'h0001);
    write_reg(wsa_pkg::CFG_FUDGE, 16'h0000);
    write_reg(wsa_pkg::CFG_FILL_VALUE, 16'h7FFF);
    write_reg(wsa_pkg::CFG_IMAGE_HEIGHT, 16'h0000);
    write_reg(wsa_pkg::CFG_IMAGE_WIDTH, 16'h07FF);
    end_writes();
    add_directed(0, 0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b1);
    add_directed(3, 3, 16'h1000, 1'b0, 16'h8000, 16'hFFFF, 1'b1);
    wait_idle();

    // widest log argument
    write_reg(wsa_pkg::CFG_FUDGE, 16'hFFFF);
    write_reg(wsa_pkg::CFG_IMAGE_HEIGHT, 16'h07FF);
    write_reg(wsa_pkg::CFG_SIM_MODE, 16'h0000);
    end_writes();
    add_directed(100, 100, 16'h1000, 1'b0, 16'h1000, 16'hFFFF, 1'b0);
    add_directed(100, 100, 16'h0000, 1'b0, 16'h0001, 16'hFFFF, 1'b1);

    for (p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      randomize_settings(p);
      n = 0;
      while (n < PHASE_TAPS) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        broken = ($urandom_range(0, 9) == 0);
        for (k = 0; k < len; k++) begin
          if (broken) add_random_tap($urandom_range(0, 1));
          else add_random_tap(k == len - 1);
        end
        n += len;
      end
    end
    wait_idle();

    $display("Run covered %0d taps in %0d windows under %0d register settings",
             taps_accepted, windows_closed, settings_used);
    $display("%0d results checked (%0d invalid), %0d taps outside the image, %0d missing",
             results_checked, invalid_results, taps_outside, taps_missing);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
